// ----- rtl/core/fds_pkg.sv -----
package fds_pkg;

  // Defaults and fixed widths
  localparam int unsigned IndexBitsDef = 16;
  localparam int unsigned NameBaseW    = 64;
  localparam int unsigned NameExtW     = 24;
  localparam int unsigned NameW        = NameBaseW + NameExtW;
  localparam int unsigned CfgDataW     = 64;
  localparam int unsigned ByteW        = 8;
  localparam int unsigned IndexOutW    = 16;
  localparam int unsigned ClusterW     = 32;
  localparam int unsigned WordW        = 16;
  localparam int unsigned PosW         = 5;

  // Directory entry layout and marks
  localparam logic [ByteW-1:0] EndMark      = 8'h00;
  localparam logic [ByteW-1:0] DeletedMark  = 8'hE5;
  localparam logic [ByteW-1:0] AttrSkipMask = 8'h0E;
  localparam logic [PosW-1:0]  NameLen      = 5'd11;
  localparam logic [PosW-1:0]  AttrPos      = 5'd11;
  localparam logic [PosW-1:0]  HighWordPos  = 5'd20;
  localparam logic [PosW-1:0]  LowWordPos   = 5'd26;
  localparam logic [PosW-1:0]  LastPos      = 5'd31;

  typedef enum logic [2:0] {
    OUTC_END       = 3'd0,
    OUTC_DELETED   = 3'd1,
    OUTC_ATTR_SKIP = 3'd2,
    OUTC_NO_MATCH  = 3'd3,
    OUTC_MATCH     = 3'd4
  } fds_outcome_e;

  typedef enum logic [1:0] {
    KIND_NORMAL  = 2'd0,
    KIND_END     = 2'd1,
    KIND_DELETED = 2'd2
  } fds_kind_e;

  typedef enum logic {
    CFG_NAME_BASE = 1'b0,
    CFG_NAME_EXT  = 1'b1
  } fds_cfg_idx_e;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             restart;
  } fds_item_t;

  typedef struct packed {
    fds_outcome_e         outcome;
    logic [IndexOutW-1:0] entry_index;
    logic [ClusterW-1:0]  start_cluster;
  } fds_result_t;

endpackage

// ----- rtl/core/fds_in_if.sv -----
interface fds_in_if;
  logic                          valid;
  logic                          ready;
  logic [fds_pkg::ByteW-1:0]     data_byte;
  logic                          restart;

  modport source (output valid, output data_byte, output restart, input ready);
  modport sink (input valid, input data_byte, input restart, output ready);
endinterface

// ----- rtl/core/fds_out_if.sv -----
interface fds_out_if;
  logic                          valid;
  logic                          ready;
  logic [2:0]                    outcome;
  logic [fds_pkg::IndexOutW-1:0] entry_index;
  logic [fds_pkg::ClusterW-1:0]  start_cluster;

  modport source (output valid, output outcome, output entry_index, output start_cluster,
                  input ready);
  modport sink (input valid, input outcome, input entry_index, input start_cluster,
                output ready);
endinterface

// ----- rtl/core/fds_in_stage.sv -----
module fds_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  fds_in_if.sink             item_i,
  input  logic               adv_i,
  output logic               valid_o,
  output fds_pkg::fds_item_t item_o
);
  import fds_pkg::*;

  logic      valid_q;
  fds_item_t item_q;

  // Take a new byte whenever the held one is empty or moving on
  assign item_i.ready = !valid_q || adv_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (item_i.ready) begin
      valid_q <= item_i.valid;
    end
  end

  // Hold payload of the last transfer
  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      item_q.data_byte <= item_i.data_byte;
      item_q.restart   <= item_i.restart;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
endmodule

// ----- rtl/core/fds_entry_track.sv -----
module fds_entry_track #(
  parameter int unsigned IndexBits = fds_pkg::IndexBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [fds_pkg::CfgDataW-1:0]  cfg_data_i,
  input  fds_pkg::fds_item_t            item_i,
  input  logic                          step_i,
  output logic                          res_valid_o,
  output fds_pkg::fds_result_t          res_o
);
  import fds_pkg::*;

  localparam int unsigned CmpW = (IndexBits > IndexOutW) ? IndexBits : IndexOutW;

  logic [NameBaseW-1:0] base_q;
  logic [NameExtW-1:0]  ext_q;

  logic [PosW-1:0]      pos_q, pos_d;
  logic [IndexBits-1:0] cnt_q, cnt_d;
  fds_kind_e            kind_q, kind_d;
  logic                 attr_q, attr_d;
  logic                 mis_q, mis_d;
  logic [WordW-1:0]     ch_q, ch_d;
  logic [WordW-1:0]     cl_q, cl_d;
  logic                 done_q, done_d;

  logic [PosW-1:0]      eff_pos;
  logic [IndexBits-1:0] eff_cnt;
  logic                 eff_done;
  logic [ByteW-1:0]     b;
  logic [NameW-1:0]     name_all;
  logic [3:0]           name_sel;
  logic [ByteW-1:0]     want;
  fds_outcome_e         outcome;
  logic [CmpW-1:0]      cnt_ext;
  logic                 is_last;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      ext_q  <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_NAME_BASE) begin
        base_q <= cfg_data_i[NameBaseW-1:0];
      end else begin
        ext_q <= cfg_data_i[NameExtW-1:0];
      end
    end
  end

  // Restart clears position, counter and done before the byte is used
  assign b        = item_i.data_byte;
  assign eff_pos  = item_i.restart ? '0 : pos_q;
  assign eff_cnt  = item_i.restart ? '0 : cnt_q;
  assign eff_done = item_i.restart ? 1'b0 : done_q;
  assign is_last  = (eff_pos == LastPos);

  // Pick the wanted name byte, first character in the top byte
  assign name_all = {base_q, ext_q};
  assign name_sel = 4'(NameLen - 5'd1) - eff_pos[3:0];
  assign want     = name_all[{name_sel, 3'b000} +: ByteW];

  // Classify the finished entry, end first, then deleted, attribute, name
  always_comb begin
    case (kind_q)
      KIND_END:     outcome = OUTC_END;
      KIND_DELETED: outcome = OUTC_DELETED;
      default: begin
        if (attr_q) begin
          outcome = OUTC_ATTR_SKIP;
        end else if (mis_q) begin
          outcome = OUTC_NO_MATCH;
        end else begin
          outcome = OUTC_MATCH;
        end
      end
    endcase
  end

  // Saturate the reported index at the port width
  assign cnt_ext = CmpW'(eff_cnt);

  always_comb begin
    res_o.outcome       = outcome;
    res_o.entry_index   = (cnt_ext > CmpW'(16'hFFFF)) ? 16'hFFFF : cnt_ext[IndexOutW-1:0];
    res_o.start_cluster = {ch_q, cl_q};
  end

  assign res_valid_o = !eff_done && is_last;

  // Next state for one byte
  always_comb begin
    pos_d  = eff_pos;
    cnt_d  = eff_cnt;
    done_d = eff_done;
    kind_d = kind_q;
    attr_d = attr_q;
    mis_d  = mis_q;
    ch_d   = ch_q;
    cl_d   = cl_q;
    if (!eff_done) begin
      pos_d = eff_pos + 5'd1;
      if (eff_pos == '0) begin
        if (b == EndMark) begin
          kind_d = KIND_END;
        end else if (b == DeletedMark) begin
          kind_d = KIND_DELETED;
        end else begin
          kind_d = KIND_NORMAL;
        end
        attr_d = 1'b0;
        mis_d  = 1'b0;
        ch_d   = '0;
        cl_d   = '0;
      end
      if (eff_pos < NameLen && b != want) begin
        mis_d = 1'b1;
      end
      if (eff_pos == AttrPos) begin
        attr_d = |(b & AttrSkipMask);
      end
      if (eff_pos == HighWordPos) begin
        ch_d[7:0] = b;
      end
      if (eff_pos == HighWordPos + 5'd1) begin
        ch_d[15:8] = b;
      end
      if (eff_pos == LowWordPos) begin
        cl_d[7:0] = b;
      end
      if (eff_pos == LowWordPos + 5'd1) begin
        cl_d[15:8] = b;
      end
      if (is_last) begin
        if (eff_cnt != '1) begin
          cnt_d = eff_cnt + 1'b1;
        end
        if (outcome == OUTC_END || outcome == OUTC_MATCH) begin
          done_d = 1'b1;
        end
      end
    end
  end

  // Advance entry state on each byte taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      cnt_q  <= '0;
      kind_q <= KIND_NORMAL;
      attr_q <= 1'b0;
      mis_q  <= 1'b0;
      ch_q   <= '0;
      cl_q   <= '0;
      done_q <= 1'b0;
    end else if (step_i) begin
      pos_q  <= pos_d;
      cnt_q  <= cnt_d;
      kind_q <= kind_d;
      attr_q <= attr_d;
      mis_q  <= mis_d;
      ch_q   <= ch_d;
      cl_q   <= cl_d;
      done_q <= done_d;
    end
  end
endmodule

// ----- rtl/core/fds_out_stage.sv -----
module fds_out_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  fds_pkg::fds_result_t res_i,
  output logic                 free_o,
  fds_out_if.source            result_o
);
  import fds_pkg::*;

  logic        valid_q;
  fds_result_t res_q;

  // Slot is free when empty or being drained this cycle
  assign free_o = !valid_q || result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  // Hold the result until its transfer
  always_ff @(posedge clk_i) begin
    if (load_i && free_o) begin
      res_q <= res_i;
    end
  end

  assign result_o.valid         = valid_q;
  assign result_o.outcome       = res_q.outcome;
  assign result_o.entry_index   = res_q.entry_index;
  assign result_o.start_cluster = res_q.start_cluster;
endmodule

// ----- rtl/core/fat32_dir_entry_scan_unit.sv -----
// Result path: a byte is registered in the input register at its transfer; the result of
//   byte 31 of an entry is loaded into the output register when that byte moves on, which
//   waits until the output slot is free, and is then offered on the result interface.
// Throughput: one byte per cycle while the output slot is free; while a result waits, one
//   more byte enters the input register and then the input stalls.
// Reset: asynchronous, active low; clears position, counter, entry flags, done and names.
module fat32_dir_entry_scan_unit #(
  parameter int unsigned INDEX_BITS = fds_pkg::IndexBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [fds_pkg::CfgDataW-1:0] cfg_data_i,
  fds_in_if.sink                       item_i,
  fds_out_if.source                    result_o
);
  import fds_pkg::*;

  logic        s1_valid;
  fds_item_t   s1_item;
  logic        out_free;
  logic        adv;
  logic        res_valid;
  fds_result_t res;

  // Move the held byte on whenever the output slot can take a result
  assign adv = s1_valid && out_free;

  fds_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_i),
    .adv_i   (adv),
    .valid_o (s1_valid),
    .item_o  (s1_item)
  );

  fds_entry_track #(
    .IndexBits (INDEX_BITS)
  ) u_entry_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .item_i      (s1_item),
    .step_i      (adv),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  fds_out_stage u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (adv && res_valid),
    .res_i    (res),
    .free_o   (out_free),
    .result_o (result_o)
  );
endmodule
